// ===== hw/rtl/tlbdp_pkg.sv =====
// Shared types and constants for the demand-paging translator.
// No dependencies.
package tlbdp_pkg;
  localparam int ADDR_BITS = 32;
  localparam int MAX_PAGE_BITS_DEF = 16;
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int FRAME_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VPN_BITS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TLB_EN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TLB_CAP = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SCAN, ST_WRITE, ST_OUT
  } state_t;
endpackage

// ===== hw/rtl/tlbdp_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module tlbdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/tlb_lru_demand_paging_translator_unit.sv =====
// Top level of the demand-paging translator with an LRU TLB.
// Depends on tlbdp_pkg and tlbdp_ram.
//
// One address at a time. After reset a clearing pass zeroes all 2^MAX_PAGE_BITS
// page-table entries (65536 by default) before any beat is taken.
// With the TLB off an address goes through accept, read, write-back and output;
// with the TLB on a search and LRU scan first runs serially over the configured
// capacity of slots and stops at a hit; only a miss then goes through the read.
// The result is held while out_stall is high. The page table is one memory
// holding a valid bit and a frame per page, read, and written back for a new page.
module tlb_lru_demand_paging_translator_unit
  import tlbdp_pkg::*;
#(
  parameter int MAX_PAGE_BITS = MAX_PAGE_BITS_DEF,
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tlbdp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tlbdp_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tlbdp_pkg::ADDR_BITS-1:0]     in_virtual_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tlbdp_pkg::ADDR_BITS-1:0]     out_physical_address,
  output logic [tlbdp_pkg::FRAME_BITS-1:0]    out_frame_number,
  output logic                                out_tlb_hit,
  output logic                                out_page_table_hit
);
  localparam int PT_DEPTH = 1 << MAX_PAGE_BITS;
  localparam int PAW = MAX_PAGE_BITS;
  localparam int TIW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CNW = $clog2(TLB_ENTRIES + 1);
  localparam int NFW = FRAME_BITS + 1;
  localparam int VBW = $clog2(MAX_PAGE_BITS + 1);

  state_t state_r, state_nxt;
  logic [4:0] vpn_bits_r;
  logic       tlb_en_r;
  logic [4:0] tlb_cap_r;

  logic [PAW-1:0] clr_r;
  logic [ADDR_BITS-1:0] va_r;
  logic [NFW-1:0] nff_r;
  logic [31:0] acc_r;

  logic [TLB_ENTRIES-1:0] tv_r;
  logic [FRAME_BITS-1:0] tp_r [TLB_ENTRIES];
  logic [FRAME_BITS-1:0] tf_r [TLB_ENTRIES];
  logic [31:0] tu_r [TLB_ENTRIES];

  logic [CNW-1:0] idx_r;
  logic hit_r, free_r;
  logic [TIW-1:0] hidx_r, vic_r;
  logic [31:0] vmin_r;

  logic [FRAME_BITS-1:0] frame_r;
  logic thit_r, pthit_r;
  logic [ADDR_BITS-1:0] pa_r;

  // effective config
  logic [VBW-1:0] vb;
  logic [5:0] offb;
  logic [CNW-1:0] cap;
  logic [ADDR_BITS-1:0] vpn_full;
  logic [PAW-1:0] pidx;
  logic [FRAME_BITS-1:0] vpn16;

  always_comb begin
    if (vpn_bits_r == 5'd0) vb = VBW'(1);
    else if (32'(vpn_bits_r) > MAX_PAGE_BITS) vb = VBW'(MAX_PAGE_BITS);
    else vb = VBW'(vpn_bits_r);
    offb = 6'(ADDR_BITS) - 6'(vb);
    if (tlb_cap_r == 5'd0) cap = CNW'(1);
    else if (32'(tlb_cap_r) > TLB_ENTRIES) cap = CNW'(TLB_ENTRIES);
    else cap = CNW'(tlb_cap_r);
    vpn_full = va_r >> offb;
    pidx = vpn_full[PAW-1:0];
    vpn16 = vpn_full[FRAME_BITS-1:0];
  end

  // page table memory: {valid, frame}
  logic pt_we;
  logic [PAW-1:0] pt_addr;
  logic [FRAME_BITS:0] pt_wdata, pt_rdata;

  tlbdp_ram #(.WIDTH(FRAME_BITS + 1), .DEPTH(PT_DEPTH)) u_pt (
    .clk(clk), .we(pt_we), .addr(pt_addr), .wdata(pt_wdata), .rdata(pt_rdata)
  );

  logic [TIW-1:0] cur;
  assign cur = idx_r[TIW-1:0];

  always_comb begin
    state_nxt = state_r;
    pt_we = 1'b0;
    pt_addr = pidx;
    pt_wdata = {1'b1, nff_r[FRAME_BITS-1:0]};
    case (state_r)
      ST_CLEAR: begin
        pt_we = 1'b1;
        pt_addr = clr_r;
        pt_wdata = '0;
        if (clr_r == {PAW{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (in_valid) state_nxt = tlb_en_r ? ST_SCAN : ST_READ;
      ST_SCAN: if (hit_r) state_nxt = ST_WRITE;
               else if (idx_r == cap) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_WRITE;
      ST_WRITE: begin
        pt_we = !hit_r && !pt_rdata[FRAME_BITS];
        state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_physical_address = pa_r;
  assign out_frame_number = frame_r;
  assign out_tlb_hit = thit_r;
  assign out_page_table_hit = pthit_r;

  logic [FRAME_BITS-1:0] fr;
  logic newpg;
  logic [ADDR_BITS-1:0] offm;
  always_comb begin
    newpg = !pt_rdata[FRAME_BITS];
    fr = hit_r ? tf_r[hidx_r] : (newpg ? nff_r[FRAME_BITS-1:0]
                                       : pt_rdata[FRAME_BITS-1:0]);
    offm = ~({ADDR_BITS{1'b1}} << offb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      vpn_bits_r <= 5'd16;
      tlb_en_r <= 1'b0;
      tlb_cap_r <= 5'd16;
      nff_r <= '0;
      acc_r <= '0;
      tv_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + PAW'(1);
      if (cfg_we) begin
        case (cfg_index)
          CFG_VPN_BITS: vpn_bits_r <= cfg_data;
          CFG_TLB_EN: tlb_en_r <= cfg_data[0];
          CFG_TLB_CAP: tlb_cap_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_WRITE) begin
        if (!hit_r && newpg && nff_r != {NFW{1'b1}}) nff_r <= nff_r + NFW'(1);
        if (tlb_en_r) begin
          if (hit_r) begin
            tu_r[hidx_r] <= acc_r;
          end else begin
            tv_r[vic_r] <= 1'b1;
            tp_r[vic_r] <= vpn16;
            tf_r[vic_r] <= fr;
            tu_r[vic_r] <= acc_r;
          end
        end
        acc_r <= acc_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      va_r <= in_virtual_address;
      idx_r <= '0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
      vic_r <= '0;
      hidx_r <= '0;
      vmin_r <= '1;
    end
    if (state_r == ST_SCAN && !hit_r && idx_r != cap) begin
      idx_r <= idx_r + CNW'(1);
      if (tv_r[cur] && tp_r[cur] == vpn16) begin
        hit_r <= 1'b1;
        hidx_r <= cur;
      end
      if (!free_r) begin
        if (!tv_r[cur]) begin
          free_r <= 1'b1;
          vic_r <= cur;
        end else if (idx_r == '0 || tu_r[cur] < vmin_r) begin
          vic_r <= cur;
          vmin_r <= tu_r[cur];
        end
      end
    end
    if (state_r == ST_WRITE) begin
      frame_r <= fr;
      thit_r <= hit_r;
      pthit_r <= hit_r || !newpg;
      pa_r <= ((ADDR_BITS'(fr)) << offb) + (va_r & offm);
    end
  end

  ap_out_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_WRITE) else $error("bad out");
  ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept while busy");
  ap_thit_pt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tlb_hit |-> out_page_table_hit) else $error("hit flags");
endmodule

// ===== verif/tlb_lru_demand_paging_translator_unit_tb.sv =====
// Testbench for the demand-paging translator with its LRU TLB.
// Drives addresses and register writes, and checks each result beat against a built-in predictor.
// Depends on tlbdp_pkg and the translator RTL.
`timescale 1ns / 1ps

module tlb_lru_demand_paging_translator_unit_tb;
  import tlbdp_pkg::*;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  phys;
    logic [FRAME_BITS-1:0] frame;
    logic                  tlb_hit;
    logic                  pt_hit;
  } xlat_t;

  typedef struct {
    logic [ADDR_BITS-1:0] va;
    bit                   has_exp;
    xlat_t                exp;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [ADDR_BITS-1:0] in_virtual_address = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [ADDR_BITS-1:0] out_physical_address;
  logic [FRAME_BITS-1:0] out_frame_number;
  logic out_tlb_hit, out_page_table_hit;

  tlb_lru_demand_paging_translator_unit dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [4:0] m_vpn_bits = 16, m_cap = 16;
  logic m_tlb_en = 0;
  bit pg_valid [65536];
  logic [15:0] pg_frame [65536];
  int unsigned free_frame = 0;
  bit tv [16];
  logic [15:0] tpage [16], tframe [16];
  logic [31:0] tuse [16];
  logic [31:0] acc_count = 0;

  xlat_t pending_q[$];
  int errors = 0;
  bit hold_rx = 0, quiet = 0;

  function automatic logic [15:0] walk_page(input logic [31:0] vpn, output bit had);
    logic [15:0] idx;
    idx = vpn[15:0];
    had = pg_valid[idx];
    if (!had) begin
      pg_valid[idx] = 1;
      pg_frame[idx] = free_frame[15:0];
      if (free_frame < 32'h1FFFF) free_frame++;
    end
    return pg_frame[idx];
  endfunction

  function automatic xlat_t translate(input logic [31:0] va);
    int vb, cap, ob, victim;
    logic [31:0] vpn, off, now;
    logic [15:0] fr;
    bit th, ph, fnd;
    xlat_t r;
    vb = m_vpn_bits == 0 ? 1 : (m_vpn_bits > 16 ? 16 : m_vpn_bits);
    cap = m_cap == 0 ? 1 : (m_cap > 16 ? 16 : m_cap);
    ob = 32 - vb;
    vpn = va >> ob;
    off = va & 32'((64'd1 << ob) - 1);
    now = acc_count;
    th = 0; ph = 0; fr = 0;
    if (m_tlb_en) begin
      for (int i = 0; i < cap; i++) begin
        if (tv[i] && tpage[i] == vpn[15:0]) begin
          th = 1; fr = tframe[i]; tuse[i] = now;
          break;
        end
      end
      if (th) begin
        ph = 1;
      end else begin
        fr = walk_page(vpn, ph);
        fnd = 0; victim = 0;
        for (int i = 0; i < cap; i++) begin
          if (!tv[i]) begin
            victim = i; fnd = 1;
            break;
          end
        end
        if (!fnd)
          for (int i = 1; i < cap; i++) if (tuse[i] < tuse[victim]) victim = i;
        tv[victim] = 1; tpage[victim] = vpn[15:0]; tframe[victim] = fr; tuse[victim] = now;
      end
    end else begin
      fr = walk_page(vpn, ph);
    end
    acc_count = now + 32'd1;
    r.phys = (32'(fr) << ob) + off;
    r.frame = fr; r.tlb_hit = th; r.pt_hit = ph;
    return r;
  endfunction

  task automatic send_beat(input logic [31:0] va, input bit has_exp, input xlat_t exp_val);
    xlat_t p;
    while (!quiet && $urandom_range(99) < 12) @(posedge clk);
    p = translate(va);
    if (has_exp && p !== exp_val) begin
      $display("%0t predictor row mismatch va=%h expected %h actual %h", $time, va, exp_val, p);
      errors++;
    end
    pending_q.push_back(p);
    in_valid <= 1;
    in_virtual_address <= va;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [4:0] val);
    while (pending_q.size() != 0) @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_VPN_BITS: m_vpn_bits = val;
      CFG_TLB_EN:   m_tlb_en = val[0];
      CFG_TLB_CAP:  m_cap = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h", $time,
                 {out_physical_address, out_frame_number, out_tlb_hit, out_page_table_hit});
        errors++;
      end else begin
        xlat_t e;
        e = pending_q.pop_front();
        if (out_physical_address !== e.phys) begin
          $display("%0t physical_address expected %h actual %h", $time, e.phys,
                   out_physical_address);
          errors++;
        end
        if (out_frame_number !== e.frame) begin
          $display("%0t frame_number expected %h actual %h", $time, e.frame, out_frame_number);
          errors++;
        end
        if (out_tlb_hit !== e.tlb_hit) begin
          $display("%0t tlb_hit expected %b actual %b", $time, e.tlb_hit, out_tlb_hit);
          errors++;
        end
        if (out_page_table_hit !== e.pt_hit) begin
          $display("%0t page_table_hit expected %b actual %b", $time, e.pt_hit,
                   out_page_table_hit);
          errors++;
        end
      end
    end
    out_stall <= hold_rx || (!quiet && $urandom_range(99) < 12);
  end

  function automatic logic [31:0] rand_addr(input int pages);
    logic [31:0] a;
    int vb;
    vb = m_vpn_bits == 0 ? 1 : (m_vpn_bits > 16 ? 16 : m_vpn_bits);
    a = $urandom;
    if ($urandom_range(3) != 0) begin
      a = a >> vb;
      a = a | (32'($urandom_range(pages - 1)) << (32 - vb));
    end
    return a;
  endfunction

  initial begin
    row_t rows[$];
    xlat_t none;
    none = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // after reset: vpn_bits 16, TLB off
    rows.push_back('{32'h0000_0000, 1, '{32'h0000_0000, 16'd0, 1'b0, 1'b0}});
    rows.push_back('{32'h0000_FFFF, 1, '{32'h0000_FFFF, 16'd0, 1'b0, 1'b1}});
    rows.push_back('{32'hFFFF_FFFF, 1, '{32'h0001_FFFF, 16'd1, 1'b0, 1'b0}});
    rows.push_back('{32'hFFFF_0000, 1, '{32'h0001_0000, 16'd1, 1'b0, 1'b1}});
    rows.push_back('{32'h1234_5678, 1, '{32'h0002_5678, 16'd2, 1'b0, 1'b0}});
    rows.push_back('{32'hAAAA_5555, 0, none});
    rows.push_back('{32'h5555_AAAA, 0, none});
    foreach (rows[i]) send_beat(rows[i].va, rows[i].has_exp, rows[i].exp);
    drain();

    // TLB on, tiny capacity: fill, hit, evict; then clamped capacity and vpn_bits
    write_reg(CFG_TLB_EN, 5'd1);
    write_reg(CFG_TLB_CAP, 5'd2);
    rows.delete();
    foreach (rows[i]) ;
    for (int i = 0; i < 10; i++)
      send_beat({16'(i % 3), 16'(i * 7)}, 0, none);
    write_reg(CFG_TLB_CAP, 5'd0);
    for (int i = 0; i < 4; i++) send_beat({16'(i % 2), 16'hBEEF}, 0, none);
    write_reg(CFG_TLB_CAP, 5'd31);
    write_reg(CFG_VPN_BITS, 5'd0);
    for (int i = 0; i < 4; i++) send_beat({i[0], 31'h7FFF_FFFF}, 0, none);
    write_reg(CFG_VPN_BITS, 5'd31);
    send_beat(32'hFFFF_FFFF, 0, none);
    drain();

    // random phases across settings
    for (int ph = 0; ph < 12; ph++) begin
      int pages;
      write_reg(CFG_VPN_BITS, ph == 0 ? 5'd1 : (ph == 1 ? 5'd16 : 5'($urandom_range(31))));
      write_reg(CFG_TLB_EN, (ph % 3 != 0) ? 5'd1 : 5'd0);
      write_reg(CFG_TLB_CAP, ph == 2 ? 5'd1 : (ph == 3 ? 5'd16 : 5'($urandom_range(31))));
      pages = 2 + $urandom_range(24);
      quiet = (ph == 4);
      if (ph == 5) begin
        fork
          begin
            hold_rx = 1;
            repeat (300) @(posedge clk);
            hold_rx = 0;
          end
        join_none
      end
      for (int n = 0; n < 125; n++) begin
        send_beat(rand_addr(pages), 0, none);
        if (ph == 6 && n == 60) while (pending_q.size() != 0) @(posedge clk);
      end
      quiet = 0;
      drain();
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
